// ===== design/rari_pkg.sv =====
// Package for the ray / axis-aligned rectangle intersection block.
// Holds payload structs, register indexes, axis codes and width constants.
`default_nettype none
package rari_pkg;
  localparam int FracBitsDef = 16;
  localparam int UvBits      = 16;
  localparam int NumWidth    = 34;
  localparam int QuoWidth    = 58;
  localparam int DivWidth    = 33;

  localparam logic [2:0] REG_NORMAL_AXIS = 3'd0;
  localparam logic [2:0] REG_PLANE       = 3'd1;
  localparam logic [2:0] REG_FIRST_LOW   = 3'd2;
  localparam logic [2:0] REG_FIRST_HIGH  = 3'd3;
  localparam logic [2:0] REG_SECOND_LOW  = 3'd4;
  localparam logic [2:0] REG_SECOND_HIGH = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] t_min;
    logic signed [31:0] t_max;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_t;
    logic        [16:0] tex_u;
    logic        [16:0] tex_v;
    logic               front_face;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } out_item_t;

  typedef struct packed {
    logic        [1:0]  normal_axis;
    logic signed [31:0] plane_offset;
    logic signed [31:0] first_low;
    logic signed [31:0] first_high;
    logic signed [31:0] second_low;
    logic signed [31:0] second_high;
  } cfg_regs_t;
endpackage
`default_nettype wire

// ===== design/rari_divu.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Generic widths; advances all stages together on en. No package use.
`default_nettype none
module rari_divu #(
  parameter int NW = 58,
  parameter int DW = 33,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side,
  output logic      [NW-1:0] quo,
  output logic      [SW-1:0] side_out
);
  logic [NW-1:0] q_r [NW+1];
  logic [DW-1:0] r_r [NW+1];
  logic [DW-1:0] d_r [NW+1];
  logic [SW-1:0] s_r [NW+1];

  always_comb begin
    q_r[0] = num;
    r_r[0] = '0;
    d_r[0] = den;
    s_r[0] = side;
  end

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    always_comb begin
      trial = {r_r[k], q_r[k][NW-1]};
      diff  = trial - {1'b0, d_r[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[DW]) begin
          r_r[k+1] <= diff[DW-1:0];
          q_r[k+1] <= {q_r[k][NW-2:0], 1'b1};
        end else begin
          r_r[k+1] <= trial[DW-1:0];
          q_r[k+1] <= {q_r[k][NW-2:0], 1'b0};
        end
        d_r[k+1] <= d_r[k];
        s_r[k+1] <= s_r[k];
      end
    end
  end

  assign quo      = q_r[NW];
  assign side_out = s_r[NW];
endmodule
`default_nettype wire

// ===== design/ray_axis_rect_intersect_top.sv =====
// Ray against axis-aligned rectangle, top level.
// Uses rari_pkg and rari_divu (three divider pipelines: t, u, v).
// One ray per cycle while the pipeline advances; from the input beat to the
// result beat lie one input register, the t divider (33+FRAC_BITS stages), four
// registers for window, products, hit point and bounds, the u and v dividers
// (49 stages, side by side) and the output register. The whole pipeline
// advances when the output register is empty or taken.
`default_nettype none
module ray_axis_rect_intersect_top #(
  parameter int FRAC_BITS = rari_pkg::FracBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rari_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rari_pkg::out_item_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import rari_pkg::*;

  localparam int TNW  = 33 + FRAC_BITS;  // |num| << FRAC_BITS
  localparam int UNW  = 33 + UvBits;
  localparam int LATT = TNW;
  localparam int LATU = UNW;
  localparam int HW   = 65 - FRAC_BITS;  // origin plus (t*d) >>> FRAC_BITS

  cfg_regs_t cfg_r;
  logic      adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_axis  <= AXIS_X;
      cfg_r.plane_offset <= '0;
      cfg_r.first_low    <= '0;
      cfg_r.first_high   <= 32'sd1 <<< FRAC_BITS;
      cfg_r.second_low   <= '0;
      cfg_r.second_high  <= 32'sd1 <<< FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NORMAL_AXIS: cfg_r.normal_axis  <= cfg_data[1:0];
        REG_PLANE:       cfg_r.plane_offset <= cfg_data;
        REG_FIRST_LOW:   cfg_r.first_low    <= cfg_data;
        REG_FIRST_HIGH:  cfg_r.first_high   <= cfg_data;
        REG_SECOND_LOW:  cfg_r.second_low   <= cfg_data;
        REG_SECOND_HIGH: cfg_r.second_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: select axis, numerator, signs
  typedef struct packed {
    logic               vld;
    logic               bad;
    logic               neg;
    logic               dneg;
    in_item_t           it;
  } s1_t;
  s1_t s1_r;
  logic [TNW-1:0] s1_num_r;
  logic [32:0]    s1_den_r;

  logic signed [31:0] on, dn;
  logic signed [32:0] numd;
  logic        [32:0] anum, aden;
  always_comb begin
    case (cfg_r.normal_axis)
      AXIS_X:  begin on = in_data.origin_x; dn = in_data.dir_x; end
      AXIS_Y:  begin on = in_data.origin_y; dn = in_data.dir_y; end
      default: begin on = in_data.origin_z; dn = in_data.dir_z; end
    endcase
    numd = 33'(cfg_r.plane_offset) - 33'(on);
    anum = numd[32] ? 33'(-numd) : numd;
    aden = dn[31] ? 33'(-34'(dn)) : 33'(dn);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_r.vld <= 1'b0;
    else if (adv) s1_r.vld <= in_valid;
    if (adv) begin
      s1_r.bad  <= (cfg_r.normal_axis == 2'd3) || (dn == 32'sd0);
      s1_r.neg  <= numd[32] ^ dn[31];
      s1_r.dneg <= dn[31];
      s1_r.it   <= in_data;
      s1_num_r  <= {anum, FRAC_BITS'(0)};
      s1_den_r  <= (dn == 32'sd0) ? 33'd1 : aden;
    end
  end

  // ---------------- t divider
  localparam int SW1 = $bits(s1_t) + 2;
  logic [TNW-1:0] tq;
  logic [SW1-1:0] tside;
  rari_divu #(.NW(TNW), .DW(33), .SW(SW1)) u_tdiv (
    .clk(clk), .en(adv), .num(s1_num_r), .den(s1_den_r),
    .side({s1_r, cfg_r.normal_axis}), .quo(tq), .side_out(tside)
  );
  s1_t        t_s;
  logic [1:0] t_ax;
  assign {t_s, t_ax} = tside;
  logic t_vld_pipe;

  // valid must clear on reset even though side data has no reset
  logic [LATT-1:0] tv_sh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) tv_sh_r <= '0;
    else if (adv) tv_sh_r <= {tv_sh_r[LATT-2:0], s1_r.vld};
  end
  assign t_vld_pipe = tv_sh_r[LATT-1];

  // ---------------- stage 2: sign t, range and window check
  typedef struct packed {
    logic               vld;
    logic               bad;
    logic               dneg;
    logic        [1:0]  ax;
    logic signed [31:0] t;
    in_item_t           it;
  } s2_t;
  s2_t s2_r;
  logic signed [TNW:0] tsg;
  logic                tovf;
  always_comb begin
    tsg  = t_s.neg ? -$signed({1'b0, tq}) : $signed({1'b0, tq});
    tovf = (tsg > $signed((TNW+1)'(32'h7fffffff))) ||
           (tsg < -$signed((TNW+1)'(33'h080000000)));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s2_r.vld <= 1'b0;
    else if (adv) s2_r.vld <= t_vld_pipe;
    if (adv) begin
      s2_r.bad  <= t_s.bad || tovf || ($signed(tsg[31:0]) < t_s.it.t_min) ||
                   ($signed(tsg[31:0]) > t_s.it.t_max);
      s2_r.dneg <= t_s.dneg;
      s2_r.ax   <= t_ax;
      s2_r.t    <= tsg[31:0];
      s2_r.it   <= t_s.it;
    end
  end

  // ---------------- stage 3: t*d products
  typedef struct packed {
    logic               vld;
    logic               bad;
    logic               dneg;
    logic        [1:0]  ax;
    logic signed [31:0] t;
    logic signed [63:0] px;
    logic signed [63:0] py;
    logic signed [63:0] pz;
    in_item_t           it;
  } s3_t;
  s3_t s3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_r.vld <= 1'b0;
    else if (adv) s3_r.vld <= s2_r.vld;
    if (adv) begin
      s3_r.bad  <= s2_r.bad;
      s3_r.dneg <= s2_r.dneg;
      s3_r.ax   <= s2_r.ax;
      s3_r.t    <= s2_r.t;
      s3_r.px   <= s2_r.t * s2_r.it.dir_x;
      s3_r.py   <= s2_r.t * s2_r.it.dir_y;
      s3_r.pz   <= s2_r.t * s2_r.it.dir_z;
      s3_r.it   <= s2_r.it;
    end
  end

  // ---------------- stage 4: hit point
  typedef struct packed {
    logic               vld;
    logic               bad;
    logic               dneg;
    logic        [1:0]  ax;
    logic signed [31:0] t;
    logic signed [HW-1:0] hx;
    logic signed [HW-1:0] hy;
    logic signed [HW-1:0] hz;
  } s4_t;
  s4_t s4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_r.vld <= 1'b0;
    else if (adv) s4_r.vld <= s3_r.vld;
    if (adv) begin
      s4_r.bad  <= s3_r.bad;
      s4_r.dneg <= s3_r.dneg;
      s4_r.ax   <= s3_r.ax;
      s4_r.t    <= s3_r.t;
      s4_r.hx   <= HW'(s3_r.it.origin_x) + HW'(s3_r.px >>> FRAC_BITS);
      s4_r.hy   <= HW'(s3_r.it.origin_y) + HW'(s3_r.py >>> FRAC_BITS);
      s4_r.hz   <= HW'(s3_r.it.origin_z) + HW'(s3_r.pz >>> FRAC_BITS);
    end
  end

  // ---------------- stage 5: bounds test, uv operands, saturation
  typedef struct packed {
    logic               vld;
    logic               bad;
    logic               dneg;
    logic               uz;
    logic               vz;
    logic signed [31:0] t;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
  } s5_t;
  s5_t s5_r;
  logic [UNW-1:0] s5_un_r, s5_vn_r;
  logic [32:0]    s5_ud_r, s5_vd_r;

  logic signed [HW-1:0] bb, cc;
  logic signed [HW-1:0] bdiff, cdiff;
  logic signed [32:0] uden, vden;
  logic               oob;
  function automatic logic signed [31:0] sat(input logic signed [HW-1:0] x);
    if (x > HW'(33'sh0_7fff_ffff)) return 32'sh7fffffff;
    if (x < HW'(-33'sh0_8000_0000)) return 32'sh80000000;
    return x[31:0];
  endfunction
  always_comb begin
    bb = (s4_r.ax == AXIS_X) ? s4_r.hy : s4_r.hx;
    cc = (s4_r.ax == AXIS_Z) ? s4_r.hy : s4_r.hz;
    oob = (bb < HW'(cfg_r.first_low)) || (bb > HW'(cfg_r.first_high)) ||
          (cc < HW'(cfg_r.second_low)) || (cc > HW'(cfg_r.second_high));
    bdiff = bb - HW'(cfg_r.first_low);
    cdiff = cc - HW'(cfg_r.second_low);
    uden  = 33'(cfg_r.first_high) - 33'(cfg_r.first_low);
    vden  = 33'(cfg_r.second_high) - 33'(cfg_r.second_low);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s5_r.vld <= 1'b0;
    else if (adv) s5_r.vld <= s4_r.vld;
    if (adv) begin
      s5_r.bad  <= s4_r.bad || oob;
      s5_r.dneg <= s4_r.dneg;
      s5_r.uz   <= (uden == 33'sd0);
      s5_r.vz   <= (vden == 33'sd0);
      s5_r.t    <= s4_r.t;
      s5_r.sx   <= sat(s4_r.hx);
      s5_r.sy   <= sat(s4_r.hy);
      s5_r.sz   <= sat(s4_r.hz);
      // in bounds, diffs are within 33 bits and nonnegative
      s5_un_r   <= {bdiff[32:0], UvBits'(0)};
      s5_vn_r   <= {cdiff[32:0], UvBits'(0)};
      s5_ud_r   <= (uden == 33'sd0) ? 33'd1 : uden;
      s5_vd_r   <= (vden == 33'sd0) ? 33'd1 : vden;
    end
  end

  // ---------------- u and v dividers
  localparam int SW5 = $bits(s5_t);
  logic [UNW-1:0] uq, vq;
  logic [SW5-1:0] uside;
  logic           vside;
  rari_divu #(.NW(UNW), .DW(33), .SW(SW5)) u_udiv (
    .clk(clk), .en(adv), .num(s5_un_r), .den(s5_ud_r),
    .side(s5_r), .quo(uq), .side_out(uside)
  );
  rari_divu #(.NW(UNW), .DW(33), .SW(1)) u_vdiv (
    .clk(clk), .en(adv), .num(s5_vn_r), .den(s5_vd_r),
    .side(s5_r.vz), .quo(vq), .side_out(vside)
  );
  s5_t u_s;
  assign u_s = uside;

  logic [LATU-1:0] uv_sh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) uv_sh_r <= '0;
    else if (adv) uv_sh_r <= {uv_sh_r[LATU-2:0], s5_r.vld};
  end

  // ---------------- output register
  out_item_t res;
  always_comb begin
    res = '0;
    if (!u_s.bad) begin
      res.hit        = 1'b1;
      res.hit_t      = u_s.t;
      res.tex_u      = u_s.uz ? 17'd0 : uq[16:0];
      res.tex_v      = vside ? 17'd0 : vq[16:0];
      res.front_face = u_s.dneg;
      res.point_x    = u_s.sx;
      res.point_y    = u_s.sy;
      res.point_z    = u_s.sz;
    end
  end

  logic out_valid_r;
  out_item_t out_data_r;
  assign adv = !out_valid_r || !out_stall;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= uv_sh_r[LATU-1];
    if (adv) out_data_r <= res;
  end

  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule
`default_nettype wire

// ===== design/rari_checker.sv =====
// Port-level checker for ray_axis_rect_intersect_top, bound to the top level.
// Uses rari_pkg payload types.
`default_nettype none
module rari_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire rari_pkg::out_item_t out_data
);
  import rari_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_stall_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.hit_t == 32'sd0 &&
      out_data.tex_u == 17'd0 && out_data.front_face == 1'b0)
    else $error("miss beat carries nonzero fields");

  a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.tex_u <= 17'd65536 && out_data.tex_v <= 17'd65536)
    else $error("texture coordinate above one");
endmodule

bind ray_axis_rect_intersect_top rari_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
